### rtl/core/ppt_pkg.sv
package ppt_pkg;

    // Command codes.
    localparam logic [2:0] CMD_DEFINE = 3'd0;
    localparam logic [2:0] CMD_FORGET = 3'd1;
    localparam logic [2:0] CMD_CHECK  = 3'd2;
    localparam logic [2:0] CMD_QUERY  = 3'd3;
    localparam logic [2:0] CMD_AUDIT  = 3'd4;
    localparam logic [2:0] CMD_STATS  = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_DENIED   = 3'd4;

    localparam logic [7:0] UNKNOWN_PROFILE = 8'd255;
    localparam int         MAX_OUT         = 16;

    // Width of the input item payload: command, key, class, mask, max_out.
    localparam int IN_W  = 3 + 64 + 8 + 32 + 5;
    // Output payload without last: 3+8+32*4+8+8+1+32.
    localparam int OUT_W = 3 + 8 + 128 + 8 + 8 + 1 + 32;

    // One decoded item handed from the front to the back.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] key;       // name, bytes past the terminator cleared
        logic        key_ok;    // length in range for a match
        logic        def_bad;   // define request is malformed
        logic        cls_bad;   // class out of range
        logic [7:0]  cls;
        logic [31:0] mask;
        logic [4:0]  maxo;
    } t_job;

    // One result item.
    typedef struct packed {
        logic [2:0]  status;
        logic        last;
        logic [7:0]  mask_out;
        logic [31:0] checks_count;
        logic [31:0] denied_count;
        logic [31:0] rejected_count;
        logic [31:0] defined_count;
        logic [7:0]  audit_profile;
        logic [7:0]  audit_class;
        logic        audit_allowed;
        logic [31:0] audit_seq;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_AUDIT,
        S_WAIT
    } t_state;

endpackage

### rtl/core/ppt_ram.sv
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/ppt_front.sv
module ppt_front #(
    parameter int NAME_BYTES  = 8,
    parameter int CLASS_COUNT = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ppt_pkg::IN_W-1:0] i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output ppt_pkg::t_job       o_job
);
    import ppt_pkg::*;

    localparam int QD = 2;

    t_job       r_q [QD];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    t_job       n_job;
    logic [3:0] len;
    logic       seen_zero;
    logic [7:0] cls;
    logic [31:0] mask;
    logic       push, pop;

    // Classify the incoming item: name length, masked key, range checks.
    always_comb begin
        n_job      = '0;
        n_job.cmd  = i_data[2:0];
        cls        = i_data[74:67];
        mask       = i_data[106:75];
        n_job.cls  = cls;
        n_job.mask = mask;
        n_job.maxo = i_data[111:107];
        len        = 4'd0;
        seen_zero  = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (i_data[3+8*b +: 8] == 8'd0) begin
                seen_zero = 1'b1;
            end
            if (!seen_zero) begin
                len = len + 4'd1;
                n_job.key[8*b +: 8] = i_data[3+8*b +: 8];
            end
        end
        n_job.key_ok  = (len != 4'd0) && (32'(len) < 32'(NAME_BYTES));
        n_job.def_bad = !n_job.key_ok || ((mask >> CLASS_COUNT) != 32'd0);
        n_job.cls_bad = cls[7] || (32'(cls) >= 32'(CLASS_COUNT));
    end

    assign o_ready = (r_cnt != 2'(QD));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Two-entry queue between front and back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_job;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QD)) else $error("queue count overflow");
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QD)) |-> !o_ready) else $error("ready while full");
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1)) else $error("lost push");
`endif
endmodule

### rtl/core/ppt_back.sv
module ppt_back #(
    parameter int PROFILE_SLOTS = 8,
    parameter int LOG_DEPTH     = 16,
    parameter int CLASS_COUNT   = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ppt_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output ppt_pkg::t_res o_res
);
    import ppt_pkg::*;

    localparam int SW = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
    localparam int LW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(MAX_OUT + 1);
    localparam int LIM = (LOG_DEPTH < MAX_OUT) ? LOG_DEPTH : MAX_OUT;

    logic [55:0] r_name [PROFILE_SLOTS];
    logic [PROFILE_SLOTS-1:0] r_used;
    logic [31:0] r_mask [PROFILE_SLOTS];
    logic [31:0] r_chk  [PROFILE_SLOTS];
    logic [31:0] r_den  [PROFILE_SLOTS];
    logic [LW-1:0] r_head;
    logic [31:0] r_total, r_sum_chk, r_sum_den, r_sum_rej, r_sum_def;

    t_state r_state, n_state;
    t_job   r_job;
    logic [CW-1:0] r_left, r_cnt;
    logic [LW-1:0] r_rd;
    logic   r_rd_ok;
    logic   r_ovalid;
    t_res   r_res;

    // Match stage: associative compare and lowest free slot.
    logic          hit, free_ok;
    logic [SW-1:0] hit_i, free_i, tgt;
    always_comb begin
        hit = 1'b0; hit_i = '0; free_ok = 1'b0; free_i = '0;
        for (int i = PROFILE_SLOTS - 1; i >= 0; i--) begin
            if (r_used[i] && r_job.key_ok && ({8'd0, r_name[i]} == r_job.key)) begin
                hit = 1'b1; hit_i = SW'(i);
            end
            if (!r_used[i]) begin
                free_ok = 1'b1; free_i = SW'(i);
            end
        end
        tgt = hit ? hit_i : free_i;
    end

    // Audit log memory.
    logic          log_we;
    logic [48:0]   log_wd, log_rd;
    logic [LW-1:0] rd_addr;
    ppt_ram #(.WIDTH(49), .DEPTH(LOG_DEPTH)) u_log (
        .i_clk(i_clk), .i_we(log_we), .i_waddr(r_head), .i_wdata(log_wd),
        .i_raddr(rd_addr), .o_rdata(log_rd)
    );

    logic        allow;
    logic [CW-1:0] n_first;
    always_comb begin
        allow = r_mask[hit_i][r_job.cls[4:0]];
        n_first = (32'(r_job.maxo) > 32'(LIM)) ? CW'(LIM) : CW'(r_job.maxo);
        if (32'(n_first) > r_total) n_first = CW'(r_total);
    end

    assign log_we = (r_state == S_EXEC) && (r_job.cmd == CMD_CHECK) && !r_job.cls_bad;
    assign log_wd = {hit ? 8'(hit_i) : UNKNOWN_PROFILE, r_job.cls,
                     hit && allow, r_total};
    assign rd_addr = r_rd;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (r_job.cmd == CMD_AUDIT && r_job.maxo != 5'd0) begin
                    n_state = (n_first == '0) ? S_IDLE : S_AUDIT;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_AUDIT: if (r_rd_ok && (!r_ovalid || i_ready) && r_left == CW'(1))
                n_state = S_WAIT;
            S_WAIT:  if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the control.
    always_comb begin
        o_ready = (r_state == S_IDLE);
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) r_job <= i_job;
    end

    // Execution of one command and result handoff.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_head <= '0; r_total <= '0;
            r_sum_chk <= '0; r_sum_den <= '0; r_sum_rej <= '0; r_sum_def <= '0;
            r_ovalid <= 1'b0; r_rd_ok <= 1'b0;
            r_left <= '0; r_cnt <= '0; r_rd <= '0;
            for (int i = 0; i < PROFILE_SLOTS; i++) begin
                r_name[i] <= '0; r_mask[i] <= '0; r_chk[i] <= '0; r_den[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == S_EXEC) begin
                r_res <= '0;
                r_res.last <= 1'b1;
                r_ovalid <= !(r_job.cmd == CMD_AUDIT && r_job.maxo != 5'd0);
                unique case (r_job.cmd)
                    CMD_DEFINE: begin
                        if (r_job.def_bad) begin
                            r_res.status <= ST_INVALID; r_sum_rej <= r_sum_rej + 1;
                        end else if (!hit && !free_ok) begin
                            r_res.status <= ST_FULL; r_sum_rej <= r_sum_rej + 1;
                        end else begin
                            r_name[tgt] <= r_job.key[55:0];
                            r_mask[tgt] <= r_job.mask;
                            r_used[tgt] <= 1'b1;
                            r_sum_def <= r_sum_def + 1;
                            r_res.status <= ST_OK;
                        end
                    end
                    CMD_FORGET: begin
                        if (!hit) r_res.status <= ST_NOTFOUND;
                        else begin
                            r_used[hit_i] <= 1'b0; r_name[hit_i] <= '0;
                            r_mask[hit_i] <= '0; r_res.status <= ST_OK;
                        end
                    end
                    CMD_CHECK: begin
                        if (r_job.cls_bad) begin
                            r_res.status <= ST_DENIED; r_sum_rej <= r_sum_rej + 1;
                        end else begin
                            r_sum_chk <= r_sum_chk + 1;
                            r_head <= (32'(r_head) == LOG_DEPTH - 1) ? '0 : r_head + 1'b1;
                            r_total <= r_total + 1;
                            r_res.audit_profile <= log_wd[48:41];
                            r_res.audit_class   <= log_wd[40:33];
                            r_res.audit_allowed <= log_wd[32];
                            r_res.audit_seq     <= log_wd[31:0];
                            r_res.status <= log_wd[32] ? ST_OK : ST_DENIED;
                            if (hit) r_chk[hit_i] <= r_chk[hit_i] + 1;
                            if (!log_wd[32]) begin
                                r_sum_den <= r_sum_den + 1;
                                if (hit) r_den[hit_i] <= r_den[hit_i] + 1;
                            end
                        end
                    end
                    CMD_QUERY: begin
                        if (!hit) r_res.status <= ST_NOTFOUND;
                        else begin
                            r_res.status <= ST_OK;
                            r_res.mask_out <= r_mask[hit_i][7:0];
                            r_res.checks_count <= r_chk[hit_i];
                            r_res.denied_count <= r_den[hit_i];
                        end
                    end
                    CMD_AUDIT: begin
                        r_res.status <= (r_job.maxo == 5'd0) ? ST_INVALID : ST_OK;
                        r_left <= n_first; r_cnt <= n_first;
                        r_rd <= (r_head == '0) ? LW'(LOG_DEPTH - 1) : r_head - 1'b1;
                        r_rd_ok <= 1'b0;
                    end
                    CMD_STATS: begin
                        r_res.status <= ST_OK;
                        r_res.checks_count <= r_sum_chk;
                        r_res.denied_count <= r_sum_den;
                        r_res.rejected_count <= r_sum_rej;
                        r_res.defined_count <= r_sum_def;
                    end
                    default: r_res.status <= ST_INVALID;
                endcase
            end else if (r_state == S_AUDIT) begin
                // The read of address r_rd lands in the next cycle.
                if (!r_rd_ok) begin
                    r_rd_ok <= 1'b1;
                end else if (!r_ovalid || i_ready) begin
                    r_res <= '0;
                    r_res.status <= ST_OK;
                    r_res.last <= (r_left == CW'(1));
                    r_res.audit_profile <= log_rd[48:41];
                    r_res.audit_class   <= log_rd[40:33];
                    r_res.audit_allowed <= log_rd[32];
                    r_res.audit_seq     <= log_rd[31:0];
                    r_ovalid <= 1'b1;
                    r_left <= r_left - 1'b1;
                    r_rd <= (r_rd == '0) ? LW'(LOG_DEPTH - 1) : r_rd - 1'b1;
                    r_rd_ok <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AUDIT) |-> (r_left <= r_cnt)) else $error("audit count");
    a_audit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AUDIT) |-> (r_left != '0)) else $error("audit underrun");
`endif
endmodule

### rtl/core/profile_permission_table.sv
// Profile permission table. One command item goes in and one result item comes
// out, except read audit, which returns up to sixteen entries newest first with
// tlast on the final one. A front stage classifies items into a two-entry queue
// and the back stage executes them: an accepted item is loaded from the queue
// into the job register while the back stage is idle, executed in the execute
// state, and its registered result is then offered until taken, before the back
// stage returns to idle for the next item. Read audit reads each returned entry
// through the registered read port of the audit log memory before offering it.
module profile_permission_table #(
    parameter int PROFILE_SLOTS = 8,
    parameter int LOG_DEPTH     = 16,
    parameter int NAME_BYTES    = 8,
    parameter int CLASS_COUNT   = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0], name_key[66:3], class_id[74:67], mask_in[106:75],
    // max_out[111:107]
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic         m_axis_tlast,
    // status[2:0], mask_out[10:3], checks_count[42:11], denied_count[74:43],
    // rejected_count[106:75], defined_count[138:107], audit_profile[146:139],
    // audit_class[154:147], audit_allowed[155], audit_seq[187:156]
    output logic [191:0] m_axis_tdata
);
    import ppt_pkg::*;

    logic q_valid, q_ready;
    t_job q_job;
    t_res res;

    ppt_front #(.NAME_BYTES(NAME_BYTES), .CLASS_COUNT(CLASS_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    ppt_back #(.PROFILE_SLOTS(PROFILE_SLOTS), .LOG_DEPTH(LOG_DEPTH),
               .CLASS_COUNT(CLASS_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {4'd0, res.audit_seq, res.audit_allowed, res.audit_class,
                           res.audit_profile, res.defined_count, res.rejected_count,
                           res.denied_count, res.checks_count, res.mask_out,
                           res.status};
endmodule

### bench/profile_permission_table_checker.sv
// Watches both streams of the profile table, predicts every result item and
// compares it field by field with what the block returns.
module profile_permission_table_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [111:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic         i_out_last,
    input  logic [191:0] i_out_data,
    output int           o_fail_count,
    output int           o_pending
);
    import ppt_pkg::*;

    localparam int SLOTS = 8;
    localparam int RING  = 16;
    localparam int CLS_N = 8;

    // Shadow copy of the table, the audit ring and the totals.
    logic [55:0] name_q [SLOTS];
    logic        used_q [SLOTS];
    logic [7:0]  mask_q [SLOTS];
    logic [31:0] chk_q  [SLOTS];
    logic [31:0] den_q  [SLOTS];
    logic [48:0] ring_q [RING];
    logic [3:0]  ring_head;
    logic [31:0] ring_total;
    logic [31:0] tot_checks, tot_denied, tot_rejected, tot_defined;

    t_res expected_results [$];

    assign o_pending = expected_results.size();

    function automatic int key_len(logic [63:0] key);
        int n;
        n = 0;
        while (n < 8 && key[8*n +: 8] != 8'd0) n++;
        return n;
    endfunction

    function automatic int lookup_profile(logic [63:0] key);
        int n;
        logic [63:0] v;
        n = key_len(key);
        if (n == 0 || n >= 8) return -1;
        v = key & ((64'd1 << (8*n)) - 64'd1);
        for (int i = 0; i < SLOTS; i++)
            if (used_q[i] && {8'd0, name_q[i]} == v) return i;
        return -1;
    endfunction

    function automatic t_res audit_result(logic [48:0] e);
        t_res r;
        r = '0;
        r.audit_profile = e[48:41];
        r.audit_class   = e[40:33];
        r.audit_allowed = e[32];
        r.audit_seq     = e[31:0];
        return r;
    endfunction

    // Apply one accepted command to the shadow state and queue its results.
    task automatic predict_command(logic [111:0] d);
        logic [2:0]  cmd;
        logic [63:0] key;
        logic signed [7:0] cls;
        logic [31:0] mask;
        int maxo, idx, n, at;
        logic [48:0] e;
        logic ok;
        t_res r;
        cmd  = d[2:0];
        key  = d[66:3];
        cls  = d[74:67];
        mask = d[106:75];
        maxo = d[111:107];
        r = '0;
        r.last = 1'b1;
        case (cmd)
            CMD_DEFINE: begin
                n = key_len(key);
                if (n == 0 || n >= 8 || (mask >> CLS_N) != 0) begin
                    tot_rejected++;
                    r.status = ST_INVALID;
                end else begin
                    idx = lookup_profile(key);
                    if (idx < 0)
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!used_q[i]) idx = i;
                    if (idx < 0) begin
                        tot_rejected++;
                        r.status = ST_FULL;
                    end else begin
                        name_q[idx] = key[55:0] & ((56'd1 << (8*n)) - 56'd1);
                        mask_q[idx] = mask[7:0];
                        used_q[idx] = 1'b1;
                        tot_defined++;
                        r.status = ST_OK;
                    end
                end
                expected_results.push_back(r);
            end
            CMD_FORGET: begin
                idx = lookup_profile(key);
                if (idx < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    used_q[idx] = 1'b0;
                    name_q[idx] = '0;
                    mask_q[idx] = '0;
                    r.status = ST_OK;
                end
                expected_results.push_back(r);
            end
            CMD_CHECK: begin
                if (cls < 0 || cls >= CLS_N) begin
                    tot_rejected++;
                    r.status = ST_DENIED;
                end else begin
                    idx = lookup_profile(key);
                    tot_checks++;
                    if (idx < 0) begin
                        ok = 1'b0;
                        e = {UNKNOWN_PROFILE, cls, 1'b0, ring_total};
                    end else begin
                        chk_q[idx]++;
                        ok = mask_q[idx][cls[2:0]];
                        if (!ok) den_q[idx]++;
                        e = {idx[7:0], cls, ok, ring_total};
                    end
                    if (!ok) tot_denied++;
                    ring_q[ring_head] = e;
                    ring_head++;
                    ring_total++;
                    r = audit_result(e);
                    r.last = 1'b1;
                    r.status = ok ? ST_OK : ST_DENIED;
                end
                expected_results.push_back(r);
            end
            CMD_QUERY: begin
                idx = lookup_profile(key);
                if (idx < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.status = ST_OK;
                    r.mask_out = mask_q[idx];
                    r.checks_count = chk_q[idx];
                    r.denied_count = den_q[idx];
                end
                expected_results.push_back(r);
            end
            CMD_AUDIT: begin
                if (maxo == 0) begin
                    r.status = ST_INVALID;
                    expected_results.push_back(r);
                end else begin
                    n = (maxo > RING) ? RING : maxo;
                    if (ring_total < n) n = ring_total;
                    for (int k = 0; k < n; k++) begin
                        at = (ring_head + RING - 1 - k) % RING;
                        r = audit_result(ring_q[at]);
                        r.status = ST_OK;
                        r.last = (k + 1 == n);
                        expected_results.push_back(r);
                    end
                end
            end
            CMD_STATS: begin
                r.status = ST_OK;
                r.checks_count = tot_checks;
                r.denied_count = tot_denied;
                r.rejected_count = tot_rejected;
                r.defined_count = tot_defined;
                expected_results.push_back(r);
            end
            default: begin
                r.status = ST_INVALID;
                expected_results.push_back(r);
            end
        endcase
    endtask

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, field, want, got);
        o_fail_count++;
    endtask

    // Compare one returned item against the oldest expectation.
    task automatic compare_result(logic lst, logic [191:0] d);
        t_res w;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item: expected none, actual %h", $time, d);
            o_fail_count++;
            return;
        end
        w = expected_results.pop_front();
        if (d[2:0] !== w.status)           report("status", w.status, d[2:0]);
        if (lst !== w.last)                report("last", w.last, lst);
        if (d[10:3] !== w.mask_out)        report("mask_out", w.mask_out, d[10:3]);
        if (d[42:11] !== w.checks_count)   report("checks_count", w.checks_count, d[42:11]);
        if (d[74:43] !== w.denied_count)   report("denied_count", w.denied_count, d[74:43]);
        if (d[106:75] !== w.rejected_count)
            report("rejected_count", w.rejected_count, d[106:75]);
        if (d[138:107] !== w.defined_count)
            report("defined_count", w.defined_count, d[138:107]);
        if (d[146:139] !== w.audit_profile)
            report("audit_profile", w.audit_profile, d[146:139]);
        if (d[154:147] !== w.audit_class)  report("audit_class", w.audit_class, d[154:147]);
        if (d[155] !== w.audit_allowed)    report("audit_allowed", w.audit_allowed, d[155]);
        if (d[187:156] !== w.audit_seq)    report("audit_seq", w.audit_seq, d[187:156]);
    endtask

    initial o_fail_count = 0;

    // Results are compared before new predictions, which cannot affect them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                name_q[i] = '0;
                used_q[i] = 1'b0;
                mask_q[i] = '0;
                chk_q[i] = '0;
                den_q[i] = '0;
            end
            for (int i = 0; i < RING; i++) ring_q[i] = '0;
            ring_head = '0;
            ring_total = '0;
            tot_checks = '0;
            tot_denied = '0;
            tot_rejected = '0;
            tot_defined = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) compare_result(i_out_last, i_out_data);
            if (i_in_valid && i_in_ready) predict_command(i_in_data);
        end
    end

endmodule

### bench/profile_permission_table_tb.sv
// Drives commands into the profile table with bursty traffic and random
// output stalls; the checker decides whether the results are right.
module profile_permission_table_tb;
    import ppt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 92;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // command, name_key, class_id, mask_in, max_out
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         m_axis_tlast;
    // status, mask_out, checks, denied, rejected, defined, profile, class,
    // allowed, seq
    logic [191:0] m_axis_tdata;

    int  fail_count;
    int  pending;
    int  idle_cycles = 0;
    bit  stim_done;
    bit  long_hold;

    // Small pool of names so defines, checks and forgets hit each other.
    logic [63:0] name_pool [6] = '{64'h41, 64'h4242, 64'h00_6f6c6c65_68,
        64'h0062_6f6f_6600, 64'h00_3635_3433_3231, 64'h005a_5a5a_5a5a_5a5a};

    profile_permission_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tdata  (m_axis_tdata)
    );

    profile_permission_table_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_last   (m_axis_tlast),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Send one item and wait until the block takes it.
    task automatic send_item(logic [2:0] cmd, logic [63:0] key, logic [7:0] cls,
                             logic [31:0] mask, logic [4:0] maxo);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {maxo, mask, cls, key, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] pick_name();
        logic [63:0] k;
        if ($urandom_range(0, 9) < 8) return name_pool[$urandom_range(0, 5)];
        k = {$urandom, $urandom};
        if ($urandom_range(0, 1)) k[8*$urandom_range(0, 7) +: 8] = 8'd0;
        return k;
    endfunction

    // Mostly legal commands on known names, with a share of broken requests.
    task automatic send_random();
        logic [2:0]  cmd;
        logic [7:0]  cls;
        logic [31:0] mask;
        logic [4:0]  maxo;
        cmd  = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        cls  = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7));
        mask = $urandom_range(0, 9) == 0 ? $urandom : 32'($urandom_range(0, 255));
        maxo = $urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(1, 16));
        send_item(cmd, pick_name(), cls, mask, maxo);
    endtask

    // Receiver: random stall pattern, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || long_hold) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        long_hold = 1'b0;
        wait (i_rst_n);
        repeat (200) @(posedge i_clk);
        long_hold = 1'b1;
        repeat (150) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            !i_rst_n || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("profile_permission_table regression: fail");
            $finish;
        end
    end

    initial begin
        int wait_cycles;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        stim_done = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty log read, bad requests, full table, all commands.
        send_item(CMD_AUDIT, 64'h41, 8'd0, 32'd0, 5'd5);
        send_item(CMD_AUDIT, 64'h41, 8'd0, 32'd0, 5'd0);
        send_item(CMD_DEFINE, 64'h0, 8'd0, 32'h1, 5'd1);
        send_item(CMD_DEFINE, 64'hffff_ffff_ffff_ffff, 8'd0, 32'h1, 5'd1);
        send_item(CMD_DEFINE, 64'h41, 8'd0, 32'h100, 5'd1);
        for (int i = 1; i <= 9; i++)
            send_item(CMD_DEFINE, 64'h30 + i, 8'd0, (i == 1) ? 32'hff : 32'h0, 5'd1);
        send_item(CMD_DEFINE, 64'h31, 8'd0, 32'h81, 5'd1);
        send_item(CMD_CHECK, 64'h31, 8'd7, 32'd0, 5'd1);
        send_item(CMD_CHECK, 64'h32, 8'd3, 32'd0, 5'd1);
        send_item(CMD_CHECK, 64'h5a, 8'd0, 32'd0, 5'd1);
        send_item(CMD_CHECK, 64'h31, 8'h80, 32'd0, 5'd1);
        send_item(CMD_CHECK, 64'h31, 8'h08, 32'd0, 5'd1);
        send_item(CMD_QUERY, 64'h31, 8'd0, 32'd0, 5'd1);
        send_item(CMD_QUERY, 64'h5a, 8'd0, 32'd0, 5'd1);
        send_item(CMD_FORGET, 64'h32, 8'd0, 32'd0, 5'd1);
        send_item(CMD_FORGET, 64'h32, 8'd0, 32'd0, 5'd1);
        send_item(CMD_AUDIT, 64'h0, 8'd0, 32'd0, 5'd31);
        send_item(CMD_STATS, 64'h0, 8'd0, 32'd0, 5'd0);
        send_item(3'd7, 64'h0, 8'd0, 32'd0, 5'd0);
        for (int i = 1; i <= 9; i++)
            send_item(CMD_FORGET, 64'h30 + i, 8'd0, 32'd0, 5'd1);

        // Random part: bursts with gaps.
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++, n++) send_random();
            gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
        end
        send_item(CMD_AUDIT, 64'h0, 8'd0, 32'd0, 5'd16);
        send_item(CMD_STATS, 64'h0, 8'd0, 32'd0, 5'd0);
        s_axis_tvalid <= 1'b0;

        // Drain, then allow trailing cycles for any stray result.
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < WATCHDOG_LIMIT * 4) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        stim_done = 1'b1;
        repeat (100) @(posedge i_clk);
        if (pending == 0 && fail_count == 0)
            $display("profile_permission_table regression: pass");
        else
            $display("profile_permission_table regression: fail");
        $finish;
    end

endmodule
